/* rtl/qrd_pkg.sv */
// Shared types and codes for the quadrature rotation decoder.
package qrd_pkg;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_FWD_BOTH = 3'd1,
        PH_FWD_B    = 3'd2,
        PH_FWD_OFF  = 3'd3,
        PH_BCK_BOTH = 3'd4,
        PH_BCK_A    = 3'd5,
        PH_BCK_OFF  = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        ROT_NONE = 2'd0,
        ROT_FWD  = 2'd1,
        ROT_BCK  = 2'd2
    } rot_t;

    typedef struct packed {
        logic step;
        logic act_a;
        logic act_b;
    } qrd_sample_t;

endpackage

/* rtl/qrd_fsm.sv */
// Detent cycle state machine of the quadrature rotation decoder.
module qrd_fsm
    import qrd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  qrd_sample_t sample,
    output rot_t        rotation
);

    phase_t phase_reg;
    phase_t phase_next;
    logic   both_idle;

    assign both_idle = !sample.act_a && !sample.act_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
        end else if (sample.step) begin
            phase_reg <= phase_next;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        rotation   = ROT_NONE;
        unique case (phase_reg)
            PH_FWD_BOTH: begin
                if (sample.act_a && sample.act_b) begin
                    phase_next = PH_FWD_B;
                end else if (both_idle) begin
                    phase_next = PH_IDLE;
                end
            end
            PH_FWD_B: begin
                if (!sample.act_a && sample.act_b) begin
                    phase_next = PH_FWD_OFF;
                end else if (both_idle) begin
                    phase_next = PH_IDLE;
                end
            end
            PH_BCK_BOTH: begin
                if (sample.act_a && sample.act_b) begin
                    phase_next = PH_BCK_A;
                end else if (both_idle) begin
                    phase_next = PH_IDLE;
                end
            end
            PH_BCK_A: begin
                if (sample.act_a && !sample.act_b) begin
                    phase_next = PH_BCK_OFF;
                end else if (both_idle) begin
                    phase_next = PH_IDLE;
                end
            end
            PH_FWD_OFF: begin
                if (both_idle) begin
                    rotation   = ROT_FWD;
                    phase_next = PH_IDLE;
                end
            end
            PH_BCK_OFF: begin
                if (both_idle) begin
                    rotation   = ROT_BCK;
                    phase_next = PH_IDLE;
                end
            end
            default: begin
                phase_next = PH_IDLE;
                if (sample.act_a != sample.act_b) begin
                    phase_next = sample.act_a ? PH_FWD_BOTH : PH_BCK_BOTH;
                end
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_report_returns_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (sample.step && rotation != ROT_NONE) |=> phase_reg == PH_IDLE)
        else $error("Phase did not return to idle after a reported step.");

    a_fwd_from_fwd_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (rotation == ROT_FWD) |-> (phase_reg == PH_FWD_OFF && both_idle))
        else $error("Forward step reported outside the final forward phase.");
`endif

endmodule

/* rtl/quadrature_rotation_decoder.sv */
// Top level of the quadrature rotation decoder with input and result registers.
//
// The decoder takes one sample of the encoder lines A and B per transfer on the
// s_ channel (s_valid, s_ready, s_line_a, s_line_b) and returns exactly one
// result per sample on the m_ channel (m_valid, m_ready, m_rotation): 0 for no
// change, 1 when a forward detent cycle completes, 2 for a backward one.
// cfg_wr_en with cfg_wr_data sets the rest level of the lines (1 for pull-up)
// and should only be written while no transfer is outstanding.
// A sample lands in the input register, passes through the state machine and
// its result is held in the result register until the receiver takes it. One
// sample is taken every cycle while the receiver keeps up.
// When m_ready is held low the result register holds its value, the input
// register fills, and s_ready then drops until the receiver takes the result.
// Synchronous reset returns the state machine to idle, empties both registers
// and sets the rest level to 1.
module quadrature_rotation_decoder
    import qrd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_line_a,
    input  logic       s_line_b,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_rotation
);

    logic        idle_level_reg;
    logic        in_valid_reg;
    logic        line_a_reg;
    logic        line_b_reg;
    logic        out_valid_reg;
    rot_t        rotation_reg;
    logic        advance;
    qrd_sample_t sample;
    rot_t        rotation;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign sample.step  = advance;
    assign sample.act_a = line_a_reg != idle_level_reg;
    assign sample.act_b = line_b_reg != idle_level_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_level_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            idle_level_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            line_a_reg <= s_line_a;
            line_b_reg <= s_line_b;
        end
    end

    qrd_fsm u_fsm (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .sample   (sample),
        .rotation (rotation)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            rotation_reg <= rotation;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_rotation = rotation_reg;

`ifndef ASSERT_OFF
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_ready)
        else $error("Input not ready although the result register is empty.");

    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("A stalled sample was lost from the input register.");

    a_rotation_code: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (rotation_reg == ROT_NONE || rotation_reg == ROT_FWD ||
                           rotation_reg == ROT_BCK))
        else $error("Result register holds an undefined rotation code.");
`endif

endmodule

/* bench/quadrature_rotation_decoder_tb.sv */
// Self-checking testbench for the quadrature rotation decoder with a predicting scoreboard.
`timescale 1ns / 100ps

module quadrature_rotation_decoder_tb;
    import qrd_pkg::*;

    class rotation_scoreboard;
        phase_t phase;
        logic   idle_level;
        rot_t   expected_q[$];
        int     errors;
        int     samples;
        int     fwd_steps;
        int     bck_steps;

        function new();
            phase      = PH_IDLE;
            idle_level = 1'b1;
            errors     = 0;
            samples    = 0;
            fwd_steps  = 0;
            bck_steps  = 0;
        endfunction

        function void set_idle_level(logic lvl);
            idle_level = lvl;
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        // Advances the detent machine by one accepted sample and queues its result.
        function void note_sample(logic line_a, logic line_b);
            logic act_a;
            logic act_b;
            logic both_idle;
            rot_t rot;
            act_a     = (line_a != idle_level);
            act_b     = (line_b != idle_level);
            both_idle = !act_a && !act_b;
            rot       = ROT_NONE;
            case (phase)
                PH_FWD_BOTH: begin
                    if (act_a && act_b) phase = PH_FWD_B;
                    else if (both_idle) phase = PH_IDLE;
                end
                PH_FWD_B: begin
                    if (!act_a && act_b) phase = PH_FWD_OFF;
                    else if (both_idle) phase = PH_IDLE;
                end
                PH_BCK_BOTH: begin
                    if (act_a && act_b) phase = PH_BCK_A;
                    else if (both_idle) phase = PH_IDLE;
                end
                PH_BCK_A: begin
                    if (act_a && !act_b) phase = PH_BCK_OFF;
                    else if (both_idle) phase = PH_IDLE;
                end
                PH_FWD_OFF: begin
                    if (both_idle) begin
                        rot   = ROT_FWD;
                        phase = PH_IDLE;
                    end
                end
                PH_BCK_OFF: begin
                    if (both_idle) begin
                        rot   = ROT_BCK;
                        phase = PH_IDLE;
                    end
                end
                default: begin
                    phase = PH_IDLE;
                    if (act_a != act_b) phase = act_a ? PH_FWD_BOTH : PH_BCK_BOTH;
                end
            endcase
            samples++;
            if (rot == ROT_FWD) fwd_steps++;
            if (rot == ROT_BCK) bck_steps++;
            expected_q.push_back(rot);
        endfunction

        function void check_rotation(logic [1:0] got);
            rot_t want;
            if (expected_q.size() == 0) begin
                $display("%0t: result transfer with nothing expected, rotation %0d", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got !== want) begin
                $display("%0t: rotation mismatch, expected %0d, actual %0d", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       cfg_wr_en;
    logic       cfg_wr_data;
    logic       s_valid;
    logic       s_ready;
    logic       s_line_a;
    logic       s_line_b;
    logic       m_valid;
    logic       m_ready;
    logic [1:0] m_rotation;

    rotation_scoreboard sb = new();
    int src_idle_pct  = 0;
    int dst_idle_pct  = 0;
    int rx_hold_cycles = 0;

    quadrature_rotation_decoder dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_line_a    (s_line_a),
        .s_line_b    (s_line_b),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_rotation  (m_rotation)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #400000;
        $display("quadrature_rotation_decoder_tb: FAIL");
        $finish;
    end

    // The receiver either holds off for a requested stretch or stalls at random.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_cycles > 0) begin
                m_ready = 1'b0;
                rx_hold_cycles--;
            end else begin
                m_ready = ($urandom_range(99) >= dst_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_rotation(m_rotation);
    end

    // Offers one sample given as active flags {A, B}, relative to the current rest level.
    task automatic send_active(logic [1:0] act);
        while ($urandom_range(99) < src_idle_pct) begin
            @(negedge aclk);
            s_valid  = 1'b0;
            s_line_a = 1'($urandom_range(1));
            s_line_b = 1'($urandom_range(1));
        end
        @(negedge aclk);
        s_valid  = 1'b1;
        s_line_a = act[1] ^ sb.idle_level;
        s_line_b = act[0] ^ sb.idle_level;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_sample(s_line_a, s_line_b);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_idle_level(logic lvl);
        drain_results();
        @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = lvl;
        sb.set_idle_level(lvl);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // Mostly complete detent cycles with bounce and stray samples, the rest pure noise.
    task automatic run_traffic(int n_items, int src_pct, int dst_pct, bit hold_off);
        logic [1:0] fwd_seq [4] = '{2'b10, 2'b11, 2'b01, 2'b00};
        logic [1:0] bck_seq [4] = '{2'b01, 2'b11, 2'b10, 2'b00};
        int  sent;
        int  reps;
        bit  backward;
        bit  held;
        sent         = 0;
        held         = 1'b0;
        src_idle_pct = src_pct;
        dst_idle_pct = dst_pct;
        while (sent < n_items) begin
            if (hold_off && !held && sent >= n_items / 2) begin
                rx_hold_cycles = 80;
                held = 1'b1;
            end
            if ($urandom_range(99) < 75) begin
                backward = 1'($urandom_range(1));
                for (int k = 0; k < 4; k++) begin
                    reps = ($urandom_range(3) == 0) ? $urandom_range(3, 2) : 1;
                    repeat (reps) begin
                        send_active(backward ? bck_seq[k] : fwd_seq[k]);
                        sent++;
                    end
                    if ($urandom_range(9) == 0) begin
                        send_active(2'($urandom_range(3)));
                        sent++;
                    end
                end
            end else begin
                repeat ($urandom_range(6, 1)) begin
                    send_active(2'($urandom_range(3)));
                    sent++;
                end
            end
        end
    endtask

    initial begin : main
        static logic [1:0] early_acts [27] = '{
            2'b00, 2'b11,
            2'b10, 2'b11, 2'b01, 2'b11, 2'b00,
            2'b01, 2'b11, 2'b10, 2'b00,
            2'b10, 2'b00,
            2'b10, 2'b11, 2'b10, 2'b00,
            2'b01, 2'b11, 2'b00,
            2'b01, 2'b00,
            2'b01, 2'b11, 2'b10, 2'b11, 2'b00
        };
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 1'b1;
        s_valid     = 1'b0;
        s_line_a    = 1'b1;
        s_line_b    = 1'b1;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        write_idle_level(1'b1);
        for (int i = 0; i < 27; i++) send_active(early_acts[i]);

        // The rest level changes after the first sample of a forward cycle; the phase is kept.
        send_active(2'b10);
        write_idle_level(1'b0);
        send_active(2'b11);
        send_active(2'b01);
        send_active(2'b00);

        run_traffic(330, 19, 56, 1'b0);
        write_idle_level(1'($urandom_range(1)));
        run_traffic(330, 56, 19, 1'b0);
        write_idle_level(1'b1);
        run_traffic(330, 0, 0, 1'b1);
        write_idle_level(1'b0);
        run_traffic(40, 0, 0, 1'b0);

        drain_results();
        if (sb.outstanding() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, sb.outstanding());
            sb.errors++;
        end
        $display("Run covered %0d samples at both rest levels, %0d forward and %0d backward",
                 sb.samples, sb.fwd_steps, sb.bck_steps);
        $display("detents, with aborted cycles, bounce, noise, stalls and a long receiver hold-off.");
        if (sb.errors == 0) begin
            $display("quadrature_rotation_decoder_tb: PASS");
        end else begin
            $display("quadrature_rotation_decoder_tb: FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/qrd_pkg.sv
rtl/qrd_fsm.sv
rtl/quadrature_rotation_decoder.sv
bench/quadrature_rotation_decoder_tb.sv
